@@ hw/rtl/feature_match_outlier_filter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Feature match outlier filter assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FEATURE_MATCH_OUTLIER_FILTER_UNIT_ASSERT_SVH
`define FEATURE_MATCH_OUTLIER_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define FMOF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmof implication check failed");

// Next-cycle implication under synchronous active-low reset.
`define FMOF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmof next-cycle check failed");

`endif

@@ hw/rtl/fmof_pkg.sv @@
// ----------------------------------------------------------------------------
// Feature match outlier filter package
// Widths, register codes and word types shared by the filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fmof_pkg;

    localparam int MAX_MATCHES_DEF = 64;

    localparam int POS_W      = 16;
    localparam int IDX_W      = 16;
    localparam int HAM_W      = 9;
    localparam int LIM_W      = 16;
    localparam int DISP_W     = 17;
    localparam int CNT_MAX_W  = 7;
    localparam int SUM_W      = 24;
    localparam int SQ_W       = 40;
    localparam int XY_W       = 41;
    localparam int STAT_W     = 50;
    localparam int U_W        = 26;
    localparam int MV_W       = 2 * U_W;
    localparam int MC_W       = MV_W + STAT_W;
    localparam int DEN_W      = 2 * STAT_W;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_W      = MC_W + FRAC_BITS + 1;
    localparam int Q_W        = 64;
    localparam int LIM_SHIFT  = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HAMMING_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 1'd1;

    localparam logic [HAM_W-1:0] HAMMING_LIMIT_RST  = 9'd64;
    localparam logic [LIM_W-1:0] DISTANCE_LIMIT_RST = 16'd2304;

    typedef struct packed {
        logic [POS_W-1:0] first_x;
        logic [POS_W-1:0] first_y;
        logic [POS_W-1:0] second_x;
        logic [POS_W-1:0] second_y;
        logic [HAM_W-1:0] hamming_dist;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
        logic             is_last;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] kept_first_index;
        logic [IDX_W-1:0] kept_second_index;
        logic [HAM_W-1:0] kept_hamming;
        logic             none_kept;
        logic             overflowed;
        logic             end_of_set;
    } t_out_word;

    typedef struct packed {
        logic signed [DISP_W-1:0] disp_x;
        logic signed [DISP_W-1:0] disp_y;
        logic [IDX_W-1:0]         first_index;
        logic [IDX_W-1:0]         second_index;
        logic [HAM_W-1:0]         hamming;
        logic                     pass;
    } t_entry;

    typedef struct packed {
        logic [CNT_MAX_W-1:0]    loaded;
        logic [CNT_MAX_W-1:0]    passing;
        logic signed [SUM_W-1:0] sum_dx;
        logic signed [SUM_W-1:0] sum_dy;
        logic [SQ_W-1:0]         sum_dx_sq;
        logic signed [XY_W-1:0]  sum_dx_dy;
        logic [SQ_W-1:0]         sum_dy_sq;
        logic                    overflow;
    } t_set_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/fmof_stream_if.sv @@
// ----------------------------------------------------------------------------
// Feature match outlier filter stream interface
// Valid/ready channel carrying one word of a configurable type.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmof_stream_if #(parameter type T_WORD = logic) ();
    logic  valid;
    logic  ready;
    T_WORD word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fmof_ram.sv @@
// ----------------------------------------------------------------------------
// Feature match outlier filter RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/fmof_queue.sv @@
// ----------------------------------------------------------------------------
// Feature match outlier filter set queue
// Two-entry queue of closed-set statistics between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module fmof_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire fmof_pkg::t_set_cmd i_cmd,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output logic                    o_full,
    output fmof_pkg::t_set_cmd      o_cmd
);

    fmof_pkg::t_set_cmd r_slot [2];
    logic               r_wptr;
    logic               r_rptr;
    logic [1:0]         r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_slot[r_wptr] <= i_cmd;
                r_wptr         <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fmof_div.sv @@
// ----------------------------------------------------------------------------
// Feature match outlier filter divider
// Restoring divider, one quotient bit per cycle, quotient saturated to 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fmof_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [fmof_pkg::NUM_W-1:0]   i_num,
    input  wire logic [fmof_pkg::DEN_W-1:0]   i_den,
    output logic                              o_done,
    output logic      [fmof_pkg::Q_W-1:0]     o_quot
);

    localparam int NUM_W = fmof_pkg::NUM_W;
    localparam int DEN_W = fmof_pkg::DEN_W;
    localparam int Q_W   = fmof_pkg::Q_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quot;
    logic             r_sat;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_sat ? {Q_W{1'b1}} : r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
                r_sat  <= 1'b0;
                r_cnt  <= CNT_W'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_quot <= {r_quot[Q_W-2:0], w_ge};
                r_sat  <= r_sat | r_quot[Q_W-1];
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fmof_front.sv @@
// ----------------------------------------------------------------------------
// Feature match outlier filter front end
// Accepts match words, stores them, classifies by Hamming distance and sums
// the displacement statistics of passing matches.
// ----------------------------------------------------------------------------
`default_nettype none

module fmof_front #(
    parameter int MAX_MATCHES = fmof_pkg::MAX_MATCHES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    fmof_stream_if.sink                           i_match,
    input  wire logic [fmof_pkg::HAM_W-1:0]       i_hamming_limit,
    input  wire logic                             i_queue_full,
    input  wire logic                             i_set_done,
    output logic                                  o_push,
    output fmof_pkg::t_set_cmd                    o_cmd,
    output logic                                  o_we,
    output logic      [$clog2(MAX_MATCHES)-1:0]   o_waddr,
    output fmof_pkg::t_entry                      o_wdata
);

    localparam int CNT_W  = $clog2(MAX_MATCHES + 1);
    localparam int ADDR_W = $clog2(MAX_MATCHES);
    localparam int DISP_W = fmof_pkg::DISP_W;
    localparam int SUM_W  = fmof_pkg::SUM_W;
    localparam int SQ_W   = fmof_pkg::SQ_W;
    localparam int XY_W   = fmof_pkg::XY_W;
    localparam int CMW    = fmof_pkg::CNT_MAX_W;

    logic [CNT_W-1:0]         r_loaded, n_loaded;
    logic [CNT_W-1:0]         r_passing, n_passing;
    logic signed [SUM_W-1:0]  r_sum_dx, n_sum_dx;
    logic signed [SUM_W-1:0]  r_sum_dy, n_sum_dy;
    logic [SQ_W-1:0]          r_sum_dx_sq, n_sum_dx_sq;
    logic signed [XY_W-1:0]   r_sum_dx_dy, n_sum_dx_dy;
    logic [SQ_W-1:0]          r_sum_dy_sq, n_sum_dy_sq;
    logic                     r_overflow, n_overflow;
    logic                     r_hold;

    logic                      w_accept;
    logic                      w_room;
    logic                      w_pass;
    logic signed [DISP_W-1:0]  w_dx;
    logic signed [DISP_W-1:0]  w_dy;
    logic signed [2*DISP_W-1:0] w_dxx;
    logic signed [2*DISP_W-1:0] w_dyy;
    logic signed [2*DISP_W-1:0] w_dxy;

    assign i_match.ready = !r_hold && !i_queue_full;
    assign w_accept      = i_match.valid && i_match.ready;
    assign w_room        = (r_loaded < CNT_W'(MAX_MATCHES));
    assign w_pass        = (i_match.word.hamming_dist <= i_hamming_limit);

    assign w_dx  = $signed({1'b0, i_match.word.second_x}) - $signed({1'b0, i_match.word.first_x});
    assign w_dy  = $signed({1'b0, i_match.word.second_y}) - $signed({1'b0, i_match.word.first_y});
    assign w_dxx = w_dx * w_dx;
    assign w_dyy = w_dy * w_dy;
    assign w_dxy = w_dx * w_dy;

    always_comb begin
        n_loaded    = r_loaded;
        n_passing   = r_passing;
        n_sum_dx    = r_sum_dx;
        n_sum_dy    = r_sum_dy;
        n_sum_dx_sq = r_sum_dx_sq;
        n_sum_dx_dy = r_sum_dx_dy;
        n_sum_dy_sq = r_sum_dy_sq;
        n_overflow  = r_overflow;
        if (w_accept) begin
            if (w_room) begin
                n_loaded = r_loaded + CNT_W'(1);
                if (w_pass) begin
                    n_passing   = r_passing + CNT_W'(1);
                    n_sum_dx    = r_sum_dx + SUM_W'(w_dx);
                    n_sum_dy    = r_sum_dy + SUM_W'(w_dy);
                    n_sum_dx_sq = r_sum_dx_sq + SQ_W'($unsigned(w_dxx));
                    n_sum_dx_dy = r_sum_dx_dy + XY_W'(w_dxy);
                    n_sum_dy_sq = r_sum_dy_sq + SQ_W'($unsigned(w_dyy));
                end
            end else begin
                n_overflow = 1'b1;
            end
        end
    end

    assign o_push            = w_accept && i_match.word.is_last;
    assign o_cmd.loaded      = CMW'(n_loaded);
    assign o_cmd.passing     = CMW'(n_passing);
    assign o_cmd.sum_dx      = n_sum_dx;
    assign o_cmd.sum_dy      = n_sum_dy;
    assign o_cmd.sum_dx_sq   = n_sum_dx_sq;
    assign o_cmd.sum_dx_dy   = n_sum_dx_dy;
    assign o_cmd.sum_dy_sq   = n_sum_dy_sq;
    assign o_cmd.overflow    = n_overflow;

    assign o_we                 = w_accept && w_room;
    assign o_waddr              = r_loaded[ADDR_W-1:0];
    assign o_wdata.disp_x       = w_dx;
    assign o_wdata.disp_y       = w_dy;
    assign o_wdata.first_index  = i_match.word.first_index;
    assign o_wdata.second_index = i_match.word.second_index;
    assign o_wdata.hamming      = i_match.word.hamming_dist;
    assign o_wdata.pass         = w_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= '0;
            r_passing   <= '0;
            r_sum_dx    <= '0;
            r_sum_dy    <= '0;
            r_sum_dx_sq <= '0;
            r_sum_dx_dy <= '0;
            r_sum_dy_sq <= '0;
            r_overflow  <= 1'b0;
            r_hold      <= 1'b0;
        end else begin
            if (o_push) begin
                r_loaded    <= '0;
                r_passing   <= '0;
                r_sum_dx    <= '0;
                r_sum_dy    <= '0;
                r_sum_dx_sq <= '0;
                r_sum_dx_dy <= '0;
                r_sum_dy_sq <= '0;
                r_overflow  <= 1'b0;
                r_hold      <= 1'b1;
            end else begin
                r_loaded    <= n_loaded;
                r_passing   <= n_passing;
                r_sum_dx    <= n_sum_dx;
                r_sum_dy    <= n_sum_dy;
                r_sum_dx_sq <= n_sum_dx_sq;
                r_sum_dx_dy <= n_sum_dx_dy;
                r_sum_dy_sq <= n_sum_dy_sq;
                r_overflow  <= n_overflow;
                if (i_set_done) begin
                    r_hold <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fmof_back.sv @@
// ----------------------------------------------------------------------------
// Feature match outlier filter back end
// Forms the set covariance, walks the stored matches, evaluates the squared
// normalized displacement with a serial multiplier and divider, and emits
// the kept matches through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fmof_back #(
    parameter int MAX_MATCHES = fmof_pkg::MAX_MATCHES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire fmof_pkg::t_set_cmd               i_cmd,
    input  wire logic                             i_cmd_valid,
    output logic                                  o_cmd_pop,
    output logic      [$clog2(MAX_MATCHES)-1:0]   o_raddr,
    input  wire fmof_pkg::t_entry                 i_rdata,
    input  wire logic [fmof_pkg::LIM_W-1:0]       i_distance_limit,
    output logic                                  o_set_done,
    fmof_stream_if.source                         o_kept
);

    localparam int CNT_W  = $clog2(MAX_MATCHES + 1);
    localparam int ADDR_W = $clog2(MAX_MATCHES);
    localparam int CMW    = fmof_pkg::CNT_MAX_W;
    localparam int STAT_W = fmof_pkg::STAT_W;
    localparam int U_W    = fmof_pkg::U_W;
    localparam int MV_W   = fmof_pkg::MV_W;
    localparam int MC_W   = fmof_pkg::MC_W;
    localparam int DEN_W  = fmof_pkg::DEN_W;
    localparam int NUM_W  = fmof_pkg::NUM_W;
    localparam int Q_W    = fmof_pkg::Q_W;
    localparam int FRAC   = fmof_pkg::FRAC_BITS;
    localparam int LIM_W  = fmof_pkg::LIM_W;
    localparam int CMP_W  = Q_W + 2;
    localparam int MCNT_W = $clog2(STAT_W + 1);

    localparam logic [3:0] B_IDLE   = 4'd0;
    localparam logic [3:0] B_PREP1  = 4'd1;
    localparam logic [3:0] B_PREP2  = 4'd2;
    localparam logic [3:0] B_ACMUL  = 4'd3;
    localparam logic [3:0] B_RD     = 4'd4;
    localparam logic [3:0] B_ENTRY  = 4'd5;
    localparam logic [3:0] B_UV     = 4'd6;
    localparam logic [3:0] B_SQ     = 4'd7;
    localparam logic [3:0] B_T1     = 4'd8;
    localparam logic [3:0] B_T2     = 4'd9;
    localparam logic [3:0] B_T3MUL  = 4'd10;
    localparam logic [3:0] B_T3     = 4'd11;
    localparam logic [3:0] B_DECIDE = 4'd12;
    localparam logic [3:0] B_EMIT   = 4'd13;
    localparam logic [3:0] B_FIN    = 4'd14;

    logic [3:0]               r_state;
    fmof_pkg::t_set_cmd       r_cmd;
    logic [CNT_W-1:0]         r_i;
    fmof_pkg::t_entry         r_entry;
    fmof_pkg::t_entry         r_pend;
    logic                     r_pend_valid;
    fmof_pkg::t_out_word      r_out;
    logic                     r_out_valid;

    logic signed [STAT_W-1:0] r_pa, r_qa, r_pc, r_qc, r_pb, r_qb;
    logic signed [STAT_W-1:0] r_a, r_b, r_c;
    logic [DEN_W-1:0]         r_ac;
    logic signed [U_W-1:0]    r_u, r_v;
    logic [MV_W-1:0]          r_vv, r_uv;
    logic                     r_neg;
    logic                     r_zero;
    logic [Q_W-1:0]           r_t1, r_t2, r_t3;

    logic [MC_W-1:0]          r_mc;
    logic [STAT_W-1:0]        r_mp;
    logic [MC_W-1:0]          r_acc;
    logic [MCNT_W-1:0]        r_mcnt;
    logic                     r_mbusy;
    logic                     r_mdone;

    logic signed [2*fmof_pkg::SUM_W-1:0] w_sxx, w_syy, w_sxy;
    logic signed [STAT_W-1:0] w_nxx, w_nyy, w_nxy;
    logic signed [STAT_W-1:0] w_a, w_c;
    logic                     w_all_keep;
    logic signed [U_W-1:0]    w_u, w_v;
    logic [U_W-1:0]           w_mu, w_mv;
    logic [MV_W-1:0]          w_uu;
    logic [STAT_W-1:0]        w_mb;
    logic                     w_mul_start;
    logic [MC_W-1:0]          w_mul_x;
    logic [STAT_W-1:0]        w_mul_y;
    logic                     w_div_start;
    logic [NUM_W-1:0]         w_num;
    logic [DEN_W-1:0]         w_den;
    logic                     w_div_done;
    logic [Q_W-1:0]           w_quot;
    logic                     w_free;
    logic                     w_out_load;
    fmof_pkg::t_out_word      w_out_word;
    logic [CMP_W-1:0]         w_pos, w_t3, w_lim;
    logic                     w_keep;

    fmof_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_sxx = r_cmd.sum_dx * r_cmd.sum_dx;
    assign w_syy = r_cmd.sum_dy * r_cmd.sum_dy;
    assign w_sxy = r_cmd.sum_dx * r_cmd.sum_dy;
    assign w_nxx = STAT_W'(r_cmd.passing * r_cmd.sum_dx_sq);
    assign w_nyy = STAT_W'(r_cmd.passing * r_cmd.sum_dy_sq);
    assign w_nxy = $signed({1'b0, r_cmd.passing}) * r_cmd.sum_dx_dy;
    assign w_a   = r_pa - r_qa;
    assign w_c   = r_pc - r_qc;
    assign w_all_keep = (r_a <= 0) || (r_c <= 0);

    assign w_u  = $signed({1'b0, r_cmd.passing}) * r_entry.disp_x - r_cmd.sum_dx;
    assign w_v  = $signed({1'b0, r_cmd.passing}) * r_entry.disp_y - r_cmd.sum_dy;
    assign w_mu = r_u[U_W-1] ? $unsigned(-r_u) : $unsigned(r_u);
    assign w_mv = r_v[U_W-1] ? $unsigned(-r_v) : $unsigned(r_v);
    assign w_uu = w_mu * w_mu;
    assign w_mb = r_b[STAT_W-1] ? $unsigned(-r_b) : $unsigned(r_b);

    always_comb begin
        w_mul_start = 1'b0;
        w_mul_x     = '0;
        w_mul_y     = '0;
        w_div_start = 1'b0;
        w_num       = '0;
        w_den       = '0;
        case (r_state)
            B_PREP2: begin
                w_mul_start = 1'b1;
                w_mul_x     = MC_W'($unsigned(w_a));
                w_mul_y     = $unsigned(w_c);
            end
            B_SQ: begin
                w_div_start = 1'b1;
                w_num       = NUM_W'({w_uu, {FRAC{1'b0}}});
                w_den       = DEN_W'($unsigned(r_a));
            end
            B_T1: begin
                w_div_start = w_div_done;
                w_num       = NUM_W'({r_vv, {FRAC{1'b0}}});
                w_den       = DEN_W'($unsigned(r_c));
            end
            B_T2: begin
                w_mul_start = w_div_done;
                w_mul_x     = MC_W'(r_uv);
                w_mul_y     = w_mb;
            end
            B_T3MUL: begin
                w_div_start = r_mdone;
                w_num       = {r_acc, {(FRAC + 1){1'b0}}};
                w_den       = r_ac;
            end
            default: begin
            end
        endcase
    end

    assign w_pos = CMP_W'(r_t1) + CMP_W'(r_t2);
    assign w_t3  = CMP_W'(r_t3);
    assign w_lim = CMP_W'({i_distance_limit, {fmof_pkg::LIM_SHIFT{1'b0}}});

    always_comb begin
        if (r_t3 == '0 || r_zero) begin
            w_keep = (w_pos <= w_lim);
        end else if (!r_neg) begin
            w_keep = (w_pos <= w_t3 + w_lim);
        end else begin
            w_keep = (w_pos + w_t3 <= w_lim);
        end
    end

    assign w_free     = !r_out_valid || o_kept.ready;
    assign w_out_load = w_free && ((r_state == B_EMIT && r_pend_valid) || r_state == B_FIN);

    always_comb begin
        w_out_word.overflowed = r_cmd.overflow;
        if (r_pend_valid) begin
            w_out_word.kept_first_index  = r_pend.first_index;
            w_out_word.kept_second_index = r_pend.second_index;
            w_out_word.kept_hamming      = r_pend.hamming;
            w_out_word.none_kept         = 1'b0;
            w_out_word.end_of_set        = (r_state == B_FIN);
        end else begin
            w_out_word.kept_first_index  = '0;
            w_out_word.kept_second_index = '0;
            w_out_word.kept_hamming      = '0;
            w_out_word.none_kept         = 1'b1;
            w_out_word.end_of_set        = 1'b1;
        end
    end

    assign o_cmd_pop    = (r_state == B_IDLE) && i_cmd_valid;
    assign o_set_done   = (r_state == B_FIN) && w_free;
    assign o_raddr      = r_i[ADDR_W-1:0];
    assign o_kept.valid = r_out_valid;
    assign o_kept.word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_mdone <= 1'b0;
            if (w_mul_start) begin
                r_mc    <= w_mul_x;
                r_mp    <= w_mul_y;
                r_acc   <= '0;
                r_mcnt  <= MCNT_W'(STAT_W);
                r_mbusy <= 1'b1;
            end else if (r_mbusy) begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc   <= {r_mc[MC_W-2:0], 1'b0};
                r_mp   <= {1'b0, r_mp[STAT_W-1:1]};
                r_mcnt <= r_mcnt - MCNT_W'(1);
                if (r_mcnt == MCNT_W'(1)) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_i          <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= w_out_word;
            end else if (o_kept.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_i     <= '0;
                        r_state <= B_PREP1;
                    end
                end
                B_PREP1: begin
                    r_pa    <= w_nxx;
                    r_qa    <= STAT_W'(w_sxx);
                    r_pc    <= w_nyy;
                    r_qc    <= STAT_W'(w_syy);
                    r_pb    <= w_nxy;
                    r_qb    <= STAT_W'(w_sxy);
                    r_state <= B_PREP2;
                end
                B_PREP2: begin
                    r_a     <= w_a;
                    r_c     <= w_c;
                    r_b     <= r_pb - r_qb;
                    r_state <= B_ACMUL;
                end
                B_ACMUL: begin
                    if (r_mdone) begin
                        r_ac    <= r_acc[DEN_W-1:0];
                        r_state <= B_RD;
                    end
                end
                B_RD: begin
                    if (CMW'(r_i) == r_cmd.loaded) begin
                        r_state <= B_FIN;
                    end else begin
                        r_state <= B_ENTRY;
                    end
                end
                B_ENTRY: begin
                    r_entry <= i_rdata;
                    if (!i_rdata.pass) begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= B_RD;
                    end else if (w_all_keep) begin
                        r_state <= B_EMIT;
                    end else begin
                        r_state <= B_UV;
                    end
                end
                B_UV: begin
                    r_u     <= w_u;
                    r_v     <= w_v;
                    r_state <= B_SQ;
                end
                B_SQ: begin
                    r_vv    <= w_mv * w_mv;
                    r_uv    <= w_mu * w_mv;
                    r_neg   <= r_b[STAT_W-1] ^ r_u[U_W-1] ^ r_v[U_W-1];
                    r_zero  <= (w_mu == '0) || (w_mv == '0) || (r_b == '0);
                    r_state <= B_T1;
                end
                B_T1: begin
                    if (w_div_done) begin
                        r_t1    <= w_quot;
                        r_state <= B_T2;
                    end
                end
                B_T2: begin
                    if (w_div_done) begin
                        r_t2    <= w_quot;
                        r_state <= B_T3MUL;
                    end
                end
                B_T3MUL: begin
                    if (r_mdone) begin
                        r_state <= B_T3;
                    end
                end
                B_T3: begin
                    if (w_div_done) begin
                        r_t3    <= w_quot;
                        r_state <= B_DECIDE;
                    end
                end
                B_DECIDE: begin
                    if (w_keep) begin
                        r_state <= B_EMIT;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= B_RD;
                    end
                end
                B_EMIT: begin
                    if (!r_pend_valid || w_free) begin
                        r_pend       <= r_entry;
                        r_pend_valid <= 1'b1;
                        r_i          <= r_i + CNT_W'(1);
                        r_state      <= B_RD;
                    end
                end
                B_FIN: begin
                    if (w_free) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/feature_match_outlier_filter_unit.sv @@
// Loading takes one word per cycle while not held; the set closes on the word marked last.
// After closing, the back end forms the covariance, then walks each stored match: one
// failing the Hamming test is skipped, one kept without the distance test is emitted,
// and the rest take three divisions on the shared divider and a multiply to decide.
// The output word waits for ready; evaluation stalls only behind a pending kept match.
// Reset is synchronous, active low; it clears counts, sums and state and reloads limits.
// ----------------------------------------------------------------------------
// Feature match outlier filter top level
// Rejects matches that fail the Hamming test or lie far from the set mean displacement.
// ----------------------------------------------------------------------------
`default_nettype none

module feature_match_outlier_filter_unit #(
    parameter int MAX_MATCHES = fmof_pkg::MAX_MATCHES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    fmof_stream_if.sink                               i_match,
    fmof_stream_if.source                             o_kept,
    input  wire logic                                 i_cfg_we,
    input  wire logic [fmof_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [fmof_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_MATCHES);

    logic [fmof_pkg::HAM_W-1:0] r_hamming_limit;
    logic [fmof_pkg::LIM_W-1:0] r_distance_limit;

    logic               w_push;
    logic               w_pop;
    logic               w_cmd_valid;
    logic               w_queue_full;
    logic               w_set_done;
    fmof_pkg::t_set_cmd w_cmd_in;
    fmof_pkg::t_set_cmd w_cmd_out;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ADDR_W-1:0]  w_raddr;
    fmof_pkg::t_entry   w_wdata;
    fmof_pkg::t_entry   w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hamming_limit  <= fmof_pkg::HAMMING_LIMIT_RST;
            r_distance_limit <= fmof_pkg::DISTANCE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fmof_pkg::CFG_HAMMING_LIMIT: begin
                    r_hamming_limit <= i_cfg_data[fmof_pkg::HAM_W-1:0];
                end
                fmof_pkg::CFG_DISTANCE_LIMIT: begin
                    r_distance_limit <= i_cfg_data[fmof_pkg::LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    fmof_front #(.MAX_MATCHES(MAX_MATCHES)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_match         (i_match),
        .i_hamming_limit (r_hamming_limit),
        .i_queue_full    (w_queue_full),
        .i_set_done      (w_set_done),
        .o_push          (w_push),
        .o_cmd           (w_cmd_in),
        .o_we            (w_we),
        .o_waddr         (w_waddr),
        .o_wdata         (w_wdata)
    );

    fmof_ram #(
        .WIDTH ($bits(fmof_pkg::t_entry)),
        .DEPTH (MAX_MATCHES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fmof_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_valid (w_cmd_valid),
        .o_full  (w_queue_full),
        .o_cmd   (w_cmd_out)
    );

    fmof_back #(.MAX_MATCHES(MAX_MATCHES)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd_out),
        .i_cmd_valid      (w_cmd_valid),
        .o_cmd_pop        (w_pop),
        .o_raddr          (w_raddr),
        .i_rdata          (w_rdata),
        .i_distance_limit (r_distance_limit),
        .o_set_done       (w_set_done),
        .o_kept           (o_kept)
    );

`include "feature_match_outlier_filter_unit_assert.svh"

    `FMOF_ASSERT_IMPLY(a_no_accept_with_open_set, i_clk, i_rst_n, i_match.valid && i_match.ready, !w_cmd_valid)
    `FMOF_ASSERT_NEXT(a_last_queues_set, i_clk, i_rst_n, w_push, w_cmd_valid)
    `FMOF_ASSERT_IMPLY(a_empty_set_ends, i_clk, i_rst_n, o_kept.valid && o_kept.word.none_kept, o_kept.word.end_of_set)

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Outlier filter testbench
// Drives sets of feature matches into the filter and checks every kept word
// against an in-bench model of the displacement statistics and distance test.
// ----------------------------------------------------------------------------
`default_nettype none

class kept_scoreboard;
    fmof_pkg::t_out_word kept_expect[$];
    int errors;
    logic [8:0] ham_limit;
    logic [15:0] dist_limit;
    longint disp_x[64];
    longint disp_y[64];
    fmof_pkg::t_in_word held[64];
    bit passes[64];
    int loaded;
    int passing;
    longint sx, sy, sxx, sxy, syy;
    bit ovf;

    function new();
        errors = 0;
        ham_limit = fmof_pkg::HAMMING_LIMIT_RST;
        dist_limit = fmof_pkg::DISTANCE_LIMIT_RST;
        clear_set();
    endfunction

    function void clear_set();
        loaded = 0;
        passing = 0;
        sx = 0;
        sy = 0;
        sxx = 0;
        sxy = 0;
        syy = 0;
        ovf = 0;
    endfunction

    function void set_limit(logic [fmof_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        if (idx == fmof_pkg::CFG_HAMMING_LIMIT) ham_limit = val[8:0];
        else dist_limit = val;
    endfunction

    function longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function bit near_mean(longint u, longint v, longint a, longint b, longint c);
        longint unsigned mu, mv, mb, lim, t1, t2, pos, t3;
        logic [127:0] num, den, quo;
        bit neg;
        mu = mag(u);
        mv = mag(v);
        mb = mag(b);
        lim = longint'(dist_limit) << 8;
        t1 = ((mu * mu) << 16) / longint'(a);
        t2 = ((mv * mv) << 16) / longint'(c);
        pos = t1 + t2;
        num = ({64'd0, mu * mv} * {64'd0, mb}) << 17;
        den = {64'd0, a} * {64'd0, c};
        quo = num / den;
        t3 = (quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
        neg = (b < 0) != ((u < 0) != (v < 0));
        if (t3 == 0 || mu == 0 || mv == 0 || mb == 0) return pos <= lim;
        if (!neg) return t3 >= pos || pos - t3 <= lim;
        return pos <= lim && t3 <= lim - pos;
    endfunction

    function void note_match(fmof_pkg::t_in_word w);
        longint dx, dy, n, a, b, c;
        bit all_keep;
        int k;
        fmof_pkg::t_out_word o;
        dx = longint'(w.second_x) - longint'(w.first_x);
        dy = longint'(w.second_y) - longint'(w.first_y);
        if (loaded < 64) begin
            disp_x[loaded] = dx;
            disp_y[loaded] = dy;
            held[loaded] = w;
            passes[loaded] = w.hamming_dist <= ham_limit;
            if (passes[loaded]) begin
                sx += dx;
                sy += dy;
                sxx += dx * dx;
                sxy += dx * dy;
                syy += dy * dy;
                passing++;
            end
            loaded++;
        end else begin
            ovf = 1;
        end
        if (!w.is_last) return;
        n = longint'(passing);
        a = n * sxx - sx * sx;
        c = n * syy - sy * sy;
        b = n * sxy - sx * sy;
        all_keep = a <= 0 || c <= 0;
        k = 0;
        for (int i = 0; i < loaded; i++) begin
            if (!passes[i]) continue;
            if (!all_keep && !near_mean(n * disp_x[i] - sx, n * disp_y[i] - sy, a, b, c))
                continue;
            o = '0;
            o.kept_first_index = held[i].first_index;
            o.kept_second_index = held[i].second_index;
            o.kept_hamming = held[i].hamming_dist;
            o.overflowed = ovf;
            kept_expect.insert(kept_expect.size(), o);
            k++;
        end
        if (k == 0) begin
            o = '0;
            o.none_kept = 1;
            o.overflowed = ovf;
            o.end_of_set = 1;
            kept_expect.insert(kept_expect.size(), o);
        end else begin
            kept_expect[kept_expect.size() - 1].end_of_set = 1;
        end
        clear_set();
    endfunction

    task report(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    task check_kept(fmof_pkg::t_out_word got);
        fmof_pkg::t_out_word want;
        if (kept_expect.size() == 0) begin
            report("unexpected kept word", longint'(got), 0);
            return;
        end
        want = kept_expect.pop_front();
        if (got.kept_first_index !== want.kept_first_index)
            report("kept_first_index", longint'(got.kept_first_index),
                   longint'(want.kept_first_index));
        if (got.kept_second_index !== want.kept_second_index)
            report("kept_second_index", longint'(got.kept_second_index),
                   longint'(want.kept_second_index));
        if (got.kept_hamming !== want.kept_hamming)
            report("kept_hamming", longint'(got.kept_hamming), longint'(want.kept_hamming));
        if (got.none_kept !== want.none_kept)
            report("none_kept", longint'(got.none_kept), longint'(want.none_kept));
        if (got.overflowed !== want.overflowed)
            report("overflowed", longint'(got.overflowed), longint'(want.overflowed));
        if (got.end_of_set !== want.end_of_set)
            report("end_of_set", longint'(got.end_of_set), longint'(want.end_of_set));
    endtask
endclass

module tb;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [fmof_pkg::CFG_IDX_W-1:0] i_cfg_index = fmof_pkg::CFG_HAMMING_LIMIT;
    logic [fmof_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    fmof_stream_if #(.T_WORD(fmof_pkg::t_in_word)) match_if ();
    fmof_stream_if #(.T_WORD(fmof_pkg::t_out_word)) kept_if ();

    kept_scoreboard sb = new();
    int burst_left = 4;
    int sent = 0;
    int stall_mode = 0;

    feature_match_outlier_filter_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_match(match_if),
        .o_kept(kept_if),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        match_if.valid = 0;
        match_if.word = '0;
        kept_if.ready = 0;
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: kept_if.ready <= 1;
            1: kept_if.ready <= 1'($urandom_range(0, 1));
            default: kept_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && kept_if.valid && kept_if.ready) sb.check_kept(kept_if.word);
    end

    initial begin
        #6000000;
        $display("feature_match_outlier_filter_unit verification failed");
        $finish;
    end

    task send_match(fmof_pkg::t_in_word w);
        match_if.valid <= 1;
        match_if.word <= w;
        do @(posedge i_clk); while (!match_if.ready);
        sb.note_match(w);
        sent++;
        burst_left--;
        if (burst_left <= 0) begin
            match_if.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task drain();
        match_if.valid <= 0;
        while (sb.kept_expect.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task write_limit(logic [fmof_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_limit(idx, val);
        @(posedge i_clk);
    endtask

    function fmof_pkg::t_in_word make_match(int cx, int cy, int spread, bit last);
        fmof_pkg::t_in_word w;
        int dx, dy, s;
        w.first_x = 16'($urandom);
        w.first_y = 16'($urandom);
        dx = cx + $urandom_range(0, 2 * spread) - spread;
        dy = cy + $urandom_range(0, 2 * spread) - spread;
        if ($urandom_range(0, 9) == 0) begin
            dx += $urandom_range(0, 4000) - 2000;
            dy += $urandom_range(0, 4000) - 2000;
        end
        s = int'(w.first_x) + dx;
        w.second_x = s < 0 ? 16'd0 : (s > 65535 ? 16'hFFFF : s[15:0]);
        s = int'(w.first_y) + dy;
        w.second_y = s < 0 ? 16'd0 : (s > 65535 ? 16'hFFFF : s[15:0]);
        w.hamming_dist = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(0, 256))
                                                      : 9'($urandom_range(0, 70));
        w.first_index = 16'($urandom);
        w.second_index = 16'($urandom);
        w.is_last = last;
        return w;
    endfunction

    task send_set(int count);
        int cx, cy, spread;
        cx = $urandom_range(0, 600) - 300;
        cy = $urandom_range(0, 600) - 300;
        spread = $urandom_range(0, 40);
        for (int i = 0; i < count; i++) send_match(make_match(cx, cy, spread, i == count - 1));
    endtask

    task send_fixed(logic [15:0] fx, fy, sx2, sy2, logic [8:0] h, bit last);
        fmof_pkg::t_in_word w;
        w.first_x = fx;
        w.first_y = fy;
        w.second_x = sx2;
        w.second_y = sy2;
        w.hamming_dist = h;
        w.first_index = 16'($urandom);
        w.second_index = 16'($urandom);
        w.is_last = last;
        send_match(w);
    endtask

    initial begin
        int size;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_fixed(16'd100, 16'd100, 16'd140, 16'd90, 9'd0, 1);
        send_fixed(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 9'd10, 0);
        send_fixed(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 9'd20, 0);
        send_fixed(16'd500, 16'd500, 16'd500, 16'd500, 9'd64, 0);
        send_fixed(16'd7, 16'd9, 16'd8, 16'd9, 9'd65, 1);
        send_fixed(16'd1, 16'd2, 16'd3, 16'd4, 9'd300 - 9'd44, 0);
        send_fixed(16'd5, 16'd6, 16'd7, 16'd8, 9'd100, 1);
        drain();
        write_limit(fmof_pkg::CFG_HAMMING_LIMIT, 16'd256);
        write_limit(fmof_pkg::CFG_DISTANCE_LIMIT, 16'd0);
        send_set(6);
        send_fixed(16'd1000, 16'd1000, 16'd1010, 16'd1020, 9'd256, 0);
        send_fixed(16'd1000, 16'd1000, 16'd1010, 16'd1020, 9'd3, 1);
        drain();
        write_limit(fmof_pkg::CFG_HAMMING_LIMIT, 16'd0);
        write_limit(fmof_pkg::CFG_DISTANCE_LIMIT, 16'hFFFF);
        send_set(4);
        drain();
        write_limit(fmof_pkg::CFG_HAMMING_LIMIT, 16'd64);
        write_limit(fmof_pkg::CFG_DISTANCE_LIMIT, 16'd2304);
        for (int s = 0; sent < 360; s++) begin
            if (s == 5 || s == 20) size = 64 + $urandom_range(0, 6);
            else if ($urandom_range(0, 9) == 0) size = 1;
            else size = $urandom_range(2, 10);
            send_set(size);
            if ($urandom_range(0, 5) == 0) begin
                drain();
                write_limit(fmof_pkg::CFG_HAMMING_LIMIT, 16'($urandom_range(0, 256)));
                write_limit(fmof_pkg::CFG_DISTANCE_LIMIT, ($urandom_range(0, 3) == 0)
                            ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(256, 4096)));
            end
        end
        drain();
        if (sb.errors == 0) begin
            $display("feature_match_outlier_filter_unit verification clean");
        end else begin
            $display("feature_match_outlier_filter_unit verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
